// ===== rtl/ephs_pkg.sv =====
// Shared types, widths and codes for the window probe hit search block.
// Depends on nothing; every other file imports it.
package ephs_pkg;

  localparam int MAX_WINDOWS = 64;
  localparam int IDX_W       = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int CNT_W       = $clog2(MAX_WINDOWS + 1);
  localparam int CFG_W       = 7;
  localparam int WIN_IDX_W   = 6;

  typedef logic signed [15:0] coord_t;
  typedef logic        [14:0] dim_t;
  typedef logic        [31:0] ident_t;
  typedef logic signed [16:0] offs_t;
  typedef logic signed [17:0] scoord_t;
  typedef logic        [2:0]  dir_t;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam dir_t DIR_NONE  = 3'd0;
  localparam dir_t DIR_DOWN  = 3'd1;
  localparam dir_t DIR_UP    = 3'd2;
  localparam dir_t DIR_LEFT  = 3'd3;
  localparam dir_t DIR_RIGHT = 3'd4;

  typedef enum logic [1:0] {
    ST_SKIP    = 2'd0,
    ST_FOUND   = 2'd1,
    ST_NONE    = 2'd2,
    ST_ILLEGAL = 2'd3
  } status_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    dim_t   width;
    dim_t   height;
    logic   solid;
    ident_t ident;
  } win_entry_t;

  typedef struct packed {
    scoord_t x_lo;
    scoord_t x_hi;
    scoord_t y_lo;
    scoord_t y_hi;
  } strip_t;

  typedef struct packed {
    logic   skip;
    logic   illegal;
    strip_t strip;
  } qdec_t;

  typedef struct packed {
    logic  hit;
    offs_t x_off;
    offs_t y_off;
  } hit_t;

endpackage

// ===== rtl/ephs_if.sv =====
// Valid/ready channel interfaces for the input item and the result item.
// Depends on ephs_pkg.
interface ephs_in_if;
  import ephs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [WIN_IDX_W-1:0] win_index;
  logic                 win_solid;
  ident_t               win_id;
  coord_t               pos_x;
  coord_t               pos_y;
  dim_t                 size_w;
  dim_t                 size_h;
  dir_t                 direction;
  logic                 object_active;

  modport source (
    output valid, req_type, win_index, win_solid, win_id, pos_x, pos_y,
           size_w, size_h, direction, object_active,
    input  ready
  );
  modport sink (
    input  valid, req_type, win_index, win_solid, win_id, pos_x, pos_y,
           size_w, size_h, direction, object_active,
    output ready
  );
endinterface

interface ephs_out_if;
  import ephs_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  ident_t  hit_id;
  offs_t   x_offset;
  offs_t   y_offset;

  modport source (output valid, status, hit_id, x_offset, y_offset, input ready);
  modport sink (input valid, status, hit_id, x_offset, y_offset, output ready);
endinterface

// ===== rtl/ephs_strip.sv =====
// Query decode: skip and illegal-side checks and the one-pixel probe strip.
// Depends on ephs_pkg.
module ephs_strip (
  input  ephs_pkg::coord_t pos_x,
  input  ephs_pkg::coord_t pos_y,
  input  ephs_pkg::dim_t   size_w,
  input  ephs_pkg::dim_t   size_h,
  input  ephs_pkg::dir_t   direction,
  input  logic             object_active,
  output ephs_pkg::qdec_t  qdec
);
  import ephs_pkg::*;

  scoord_t px;
  scoord_t py;
  scoord_t sw;
  scoord_t sh;

  assign px = {{2{pos_x[15]}}, pos_x};
  assign py = {{2{pos_y[15]}}, pos_y};
  assign sw = {3'b000, size_w};
  assign sh = {3'b000, size_h};

  always_comb begin
    qdec.skip    = (direction == DIR_NONE) || !object_active;
    qdec.illegal = 1'b0;
    qdec.strip   = '0;
    case (direction)
      DIR_DOWN: begin
        qdec.strip.x_lo = px;
        qdec.strip.x_hi = px + sw;
        qdec.strip.y_lo = py + sh;
        qdec.strip.y_hi = py + sh + 18'sd1;
      end
      DIR_UP: begin
        qdec.strip.x_lo = px;
        qdec.strip.x_hi = px + sw;
        qdec.strip.y_lo = py - 18'sd1;
        qdec.strip.y_hi = py;
      end
      DIR_LEFT: begin
        qdec.strip.x_lo = px - 18'sd1;
        qdec.strip.x_hi = px;
        qdec.strip.y_lo = py;
        qdec.strip.y_hi = py + sh;
      end
      DIR_RIGHT: begin
        qdec.strip.x_lo = px + sw;
        qdec.strip.x_hi = px + sw + 18'sd1;
        qdec.strip.y_lo = py;
        qdec.strip.y_hi = py + sh;
      end
      default: begin
        qdec.illegal = 1'b1;
      end
    endcase
  end

endmodule

// ===== rtl/ephs_table.sv =====
// Window table: one write port, one read port with registered read data.
// Depends on ephs_pkg.
module ephs_table (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ephs_pkg::IDX_W-1:0] waddr,
  input  ephs_pkg::win_entry_t       wdata,
  input  logic [ephs_pkg::IDX_W-1:0] raddr,
  output ephs_pkg::win_entry_t       rdata
);
  import ephs_pkg::*;

  win_entry_t mem [MAX_WINDOWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ephs_cmp.sv =====
// Shared compare unit: overlap test of one table entry against the probe
// strip, and the object offset from that entry. Depends on ephs_pkg.
module ephs_cmp (
  input  ephs_pkg::win_entry_t entry,
  input  ephs_pkg::strip_t     strip,
  input  ephs_pkg::coord_t     obj_x,
  input  ephs_pkg::coord_t     obj_y,
  output ephs_pkg::hit_t       res
);
  import ephs_pkg::*;

  scoord_t l;
  scoord_t r;
  scoord_t t;
  scoord_t b;

  assign l = {{2{entry.left[15]}}, entry.left};
  assign t = {{2{entry.top[15]}}, entry.top};
  assign r = l + scoord_t'({3'b000, entry.width});
  assign b = t + scoord_t'({3'b000, entry.height});

  assign res.hit   = entry.solid && (l < strip.x_hi) && (r > strip.x_lo) &&
                     (t < strip.y_hi) && (b > strip.y_lo);
  assign res.x_off = {obj_x[15], obj_x} - {entry.left[15], entry.left};
  assign res.y_off = {obj_y[15], obj_y} - {entry.top[15], entry.top};

endmodule

// ===== rtl/edge_probe_window_hit_search_top.sv =====
// A load item writes one window entry. A query item that is skipped, has an
// illegal side or finds a window_count of zero goes straight to the result
// state; otherwise the entries in use (window_count, capped at the table depth)
// are scanned one per cycle through the single table read port and one shared
// compare unit, stopping at the first solid hit.
// The result sits in an output register, and the next item is accepted while
// it waits; a query finishing while that register is still full holds until it
// drains. No clearing pass is run after reset.
//
// Top level of the window probe hit search: sequencer, config register,
// result register. Depends on ephs_pkg, ephs_if, ephs_strip, ephs_table, ephs_cmp.
module edge_probe_window_hit_search_top (
  input  logic                       clk,
  input  logic                       rst_n,
  ephs_in_if.sink                    in_ch,
  ephs_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [ephs_pkg::CFG_W-1:0] cfg_wdata
);
  import ephs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_RESULT = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   count_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  strip_t             strip_r, strip_nxt;
  coord_t             px_r, px_nxt;
  coord_t             py_r, py_nxt;
  status_t            res_status_r, res_status_nxt;
  ident_t             res_id_r, res_id_nxt;
  offs_t              res_xo_r, res_xo_nxt;
  offs_t              res_yo_r, res_yo_nxt;
  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  ident_t             out_id_r, out_id_nxt;
  offs_t              out_xo_r, out_xo_nxt;
  offs_t              out_yo_r, out_yo_nxt;

  logic               in_acc;
  logic [CNT_W-1:0]   n_lim;
  logic               last;
  qdec_t              qdec;
  hit_t               hit;
  win_entry_t         wdata;
  win_entry_t         rdata;
  logic               tbl_we;
  logic [IDX_W-1:0]   rd_addr;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    if (int'(count_r) > MAX_WINDOWS) begin
      n_lim = CNT_W'(MAX_WINDOWS);
    end else begin
      n_lim = CNT_W'(count_r);
    end
  end

  assign last = ((CNT_W'(idx_r) + CNT_W'(1)) == n_lim);

  ephs_strip u_strip (
    .pos_x         (in_ch.pos_x),
    .pos_y         (in_ch.pos_y),
    .size_w        (in_ch.size_w),
    .size_h        (in_ch.size_h),
    .direction     (in_ch.direction),
    .object_active (in_ch.object_active),
    .qdec          (qdec)
  );

  assign wdata.left   = in_ch.pos_x;
  assign wdata.top    = in_ch.pos_y;
  assign wdata.width  = in_ch.size_w;
  assign wdata.height = in_ch.size_h;
  assign wdata.solid  = in_ch.win_solid;
  assign wdata.ident  = in_ch.win_id;

  assign tbl_we  = in_acc && (in_ch.req_type == REQ_LOAD) &&
                   (int'(in_ch.win_index) < MAX_WINDOWS);
  assign rd_addr = (state_r == S_SCAN) ? idx_r + IDX_W'(1) : '0;

  ephs_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (IDX_W'(in_ch.win_index)),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  ephs_cmp u_cmp (
    .entry (rdata),
    .strip (strip_r),
    .obj_x (px_r),
    .obj_y (py_r),
    .res   (hit)
  );

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    strip_nxt      = strip_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_xo_nxt     = res_xo_r;
    res_yo_nxt     = res_yo_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_xo_nxt     = out_xo_r;
    out_yo_nxt     = out_yo_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.req_type == REQ_QUERY)) begin
          res_id_nxt = '0;
          res_xo_nxt = '0;
          res_yo_nxt = '0;
          idx_nxt    = '0;
          strip_nxt  = qdec.strip;
          px_nxt     = in_ch.pos_x;
          py_nxt     = in_ch.pos_y;
          if (qdec.skip) begin
            res_status_nxt = ST_SKIP;
            state_nxt      = S_RESULT;
          end else if (qdec.illegal) begin
            res_status_nxt = ST_ILLEGAL;
            state_nxt      = S_RESULT;
          end else if (n_lim == '0) begin
            res_status_nxt = ST_NONE;
            state_nxt      = S_RESULT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit.hit) begin
          res_status_nxt = ST_FOUND;
          res_id_nxt     = rdata.ident;
          res_xo_nxt     = hit.x_off;
          res_yo_nxt     = hit.y_off;
          state_nxt      = S_RESULT;
        end else if (last) begin
          res_status_nxt = ST_NONE;
          state_nxt      = S_RESULT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_xo_nxt     = res_xo_r;
          out_yo_nxt     = res_yo_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    strip_r      <= strip_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_xo_r     <= res_xo_nxt;
    res_yo_r     <= res_yo_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_xo_r     <= out_xo_nxt;
    out_yo_r     <= out_yo_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.hit_id   = out_id_r;
  assign out_ch.x_offset = out_xo_r;
  assign out_ch.y_offset = out_yo_r;

  a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !in_ch.ready)
    else $error("input ready during scan");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CNT_W'(idx_r) < n_lim))
    else $error("scan index beyond entries in use");

  a_skip_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.req_type == REQ_QUERY) && qdec.skip |=> (state_r == S_RESULT))
    else $error("skipped item entered scan");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r == S_RESULT))
    else $error("result item without finished query");

endmodule
